FILE: rtl/lksd_pkg.sv
package lksd_pkg;

	// directory size
	localparam int MAX_ENTRIES = 256;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	// field widths
	localparam int COORD_W = 32;
	localparam int KEY_W   = 2 * COORD_W;
	localparam int FUNC_W  = 3;
	localparam int CAP_W   = 9;
	localparam int SLOT_W  = 8;
	localparam int OCC_W   = 9;

	// stream widths
	localparam int S_TDATA_W = KEY_W;
	localparam int S_TUSER_W = FUNC_W;
	localparam int M_TDATA_W = ((SLOT_W + OCC_W + 7) / 8) * 8;
	localparam int M_TUSER_W = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP_INSERT = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_TOUCH         = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_PROBE         = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE        = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR         = 3'd4;

	// update request to the cell array
	typedef struct packed {
		logic clear;
		logic promote;
		logic remove;
		logic insert;
		logic evict;
	} cell_cmd_t;

	// update request to the free-slot stack
	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} free_cmd_t;

endpackage

FILE: rtl/lksd_ram.sv
module lksd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/lksd_free_stack.sv
module lksd_free_stack
	import lksd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  free_cmd_t        cmd,
	input  logic [IDX_W-1:0] push_slot,
	output logic [IDX_W-1:0] top,
	output logic [CNT_W-1:0] count,
	output logic [CNT_W-1:0] count_nxt
);

	// top entry lives in a register, the rest in RAM; the RAM read port
	// always prefetches the entry just below the top
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] top_q;
	logic [IDX_W-1:0] byp_q;
	logic             byp_sel_q;

	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [IDX_W-1:0] raddr;
	logic [IDX_W-1:0] rdata;
	logic [IDX_W-1:0] below;

	always_comb begin
		count_nxt = cnt_q;
		if (cmd.clear) begin
			count_nxt = '0;
		end else if (cmd.push) begin
			count_nxt = cnt_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_nxt = cnt_q - CNT_W'(1);
		end
	end

	assign we    = cmd.push;
	assign waddr = IDX_W'(cnt_q - CNT_W'(1));
	assign raddr = IDX_W'(count_nxt - CNT_W'(2));
	assign below = byp_sel_q ? byp_q : rdata;

	lksd_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(top_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			byp_sel_q <= 1'b0;
		end else begin
			cnt_q     <= count_nxt;
			byp_sel_q <= we && (waddr == raddr);
		end
	end

	always_ff @(posedge clk) begin
		byp_q <= top_q;
		if (cmd.push) begin
			top_q <= push_slot;
		end else if (cmd.pop) begin
			top_q <= below;
		end
	end

	assign top   = top_q;
	assign count = cnt_q;

endmodule

FILE: rtl/lksd_cells.sv
module lksd_cells
	import lksd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [KEY_W-1:0] key,
	input  cell_cmd_t        cmd,
	input  logic [IDX_W-1:0] ins_slot,
	output logic             hit,
	output logic [IDX_W-1:0] hit_slot,
	output logic [IDX_W-1:0] last_slot
);

	localparam int LVL = $clog2(MAX_ENTRIES);

	// cell 0 is the most recent; valid cells are always packed from cell 0
	logic [KEY_W-1:0]       key_q   [MAX_ENTRIES];
	logic [IDX_W-1:0]       slot_q  [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;

	logic [MAX_ENTRIES-1:0] match;
	logic [MAX_ENTRIES-1:0] pre_incl;
	logic [MAX_ENTRIES-1:0] pre_excl;
	logic [MAX_ENTRIES-1:0] last;
	logic [MAX_ENTRIES-1:0] pfx [LVL+1];

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == key);
		end
	end

	// keys are unique, so match is one-hot or empty
	assign hit = |match;

	// pre_incl[i]: match at cell i or below it (log-depth prefix OR)
	always_comb begin
		pfx[0] = match;
		for (int d = 0; d < LVL; d++) begin
			pfx[d+1] = pfx[d] | (pfx[d] << (1 << d));
		end
	end

	assign pre_incl = pfx[LVL];
	assign pre_excl = pre_incl << 1;
	assign last     = valid_q & ~(valid_q >> 1);

	always_comb begin
		hit_slot  = '0;
		last_slot = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit_slot  = hit_slot  | (match[i] ? slot_q[i] : '0);
			last_slot = last_slot | (last[i]  ? slot_q[i] : '0);
		end
	end

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		logic [KEY_W-1:0] up_key;
		logic [IDX_W-1:0] up_slot;
		logic             up_vld;
		logic [KEY_W-1:0] dn_key;
		logic [IDX_W-1:0] dn_slot;
		logic             dn_vld;
		logic             take_up;
		logic             take_dn;

		if (g == 0) begin : g_head
			assign up_key  = key;
			assign up_slot = ins_slot;
			assign up_vld  = 1'b1;
		end else begin : g_body
			assign up_key  = key_q[g-1];
			assign up_slot = slot_q[g-1];
			assign up_vld  = valid_q[g-1];
		end

		if (g == MAX_ENTRIES - 1) begin : g_tail
			assign dn_key  = key_q[g];
			assign dn_slot = slot_q[g];
			assign dn_vld  = 1'b0;
		end else begin : g_mid
			assign dn_key  = key_q[g+1];
			assign dn_slot = slot_q[g+1];
			assign dn_vld  = valid_q[g+1];
		end

		// promote: cells up to the hit shift toward the tail
		// remove: cells from the hit on close the gap
		assign take_up = cmd.insert || (cmd.promote && !pre_excl[g]);
		assign take_dn = cmd.remove && pre_incl[g];

		always_ff @(posedge clk) begin
			if (take_up) begin
				key_q[g]  <= up_key;
				slot_q[g] <= up_slot;
			end else if (take_dn) begin
				key_q[g]  <= dn_key;
				slot_q[g] <= dn_slot;
			end
		end

		// an evicting insert keeps the count of valid cells
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[g] <= 1'b0;
			end else if (cmd.clear) begin
				valid_q[g] <= 1'b0;
			end else if (cmd.insert && !cmd.evict) begin
				valid_q[g] <= up_vld;
			end else if (take_dn) begin
				valid_q[g] <= dn_vld;
			end
		end
	end

endmodule

FILE: rtl/lru_key_slot_directory.sv
// Fully associative key-to-slot directory with LRU ordering. Each item on the
// s_ stream carries an operation in s_tuser (lookup-or-insert, lookup-and-touch,
// probe, remove, clear) and a signed (key_x, key_z) key in s_tdata; each item
// yields exactly one result item on the m_ stream with hit/inserted/evicted
// flags, the slot and the occupancy after the operation. Each accepted item
// passes the input register, then the result register, and one item is taken
// every cycle as long as m_tready stays high: all 256 cells compare the key in
// parallel and the recency shift, slot choice and result are settled in the
// logic between the input register and the result register, so that path is
// the one that sets the clock. New slots come from the most recently freed slot,
// then from never-used slots below the capacity register, and only then by
// evicting the least recently used entry. Capacity is written on cfg_* while
// the block is idle, a rule for the user that the block does not enforce; 0 acts
// as 1 and values above 256 act as 256. No clearing pass is needed after reset.
module lru_key_slot_directory
	import lksd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CAP_W-1:0]     cfg_data,   // capacity

	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,    // key_x[31:0], key_z[63:32]
	input  logic [S_TUSER_W-1:0] s_tuser,    // func[2:0]

	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,    // slot[7:0], occupancy[16:8], zero pad
	output logic [M_TUSER_W-1:0] m_tuser     // hit[0], inserted[1], evicted[2]
);

	// input register
	logic              vld_s1;
	logic [FUNC_W-1:0] func_s1;
	logic [KEY_W-1:0]  key_s1;

	// result register
	logic              out_vld_q;
	logic              res_hit_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_ins_q;
	logic              res_evc_q;
	logic [OCC_W-1:0]  res_occ_q;

	logic [CAP_W-1:0]  cap_q;
	logic [CNT_W-1:0]  used_q;

	logic              fire;
	logic [CNT_W-1:0]  eff_cap;

	// cell array / free stack hookup
	cell_cmd_t         cell_cmd_raw;
	cell_cmd_t         cell_cmd;
	free_cmd_t         free_cmd_raw;
	free_cmd_t         free_cmd;
	logic              hit;
	logic [IDX_W-1:0]  hit_slot;
	logic [IDX_W-1:0]  last_slot;
	logic [IDX_W-1:0]  ins_slot;
	logic [IDX_W-1:0]  free_top;
	logic [CNT_W-1:0]  free_cnt;
	logic [CNT_W-1:0]  free_cnt_nxt;

	// result in flight
	logic              r_hit;
	logic [IDX_W-1:0]  r_slot;
	logic              r_ins;
	logic              r_evc;
	logic [CNT_W-1:0]  used_nxt;
	logic [CNT_W-1:0]  occ_nxt;

	// item in s1 completes when the result register is free or draining
	assign fire      = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready  = !vld_s1 || fire;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	// key is x:z with x in the upper half
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser;
			key_s1  <= {s_tdata[COORD_W-1:0], s_tdata[KEY_W-1:COORD_W]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// clamp capacity into 1..MAX_ENTRIES
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (32'(cap_q) > 32'(MAX_ENTRIES)) begin
			eff_cap = CNT_W'(MAX_ENTRIES);
		end else begin
			eff_cap = CNT_W'(cap_q);
		end
	end

	lksd_cells u_cells (
		.clk      (clk),
		.arst_n   (arst_n),
		.key      (key_s1),
		.cmd      (cell_cmd),
		.ins_slot (ins_slot),
		.hit      (hit),
		.hit_slot (hit_slot),
		.last_slot(last_slot)
	);

	lksd_free_stack u_free (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (free_cmd),
		.push_slot(hit_slot),
		.top      (free_top),
		.count    (free_cnt),
		.count_nxt(free_cnt_nxt)
	);

	// operation decode
	always_comb begin
		cell_cmd_raw = '0;
		free_cmd_raw = '0;
		r_hit        = 1'b0;
		r_slot       = '0;
		r_ins        = 1'b0;
		r_evc        = 1'b0;
		used_nxt     = used_q;
		ins_slot     = hit_slot;   // promote rewrites cell 0 with the hit slot
		case (func_s1)
			FUNC_LOOKUP_INSERT: begin
				if (hit) begin
					r_hit                = 1'b1;
					r_slot               = hit_slot;
					cell_cmd_raw.promote = 1'b1;
				end else begin
					r_ins               = 1'b1;
					cell_cmd_raw.insert = 1'b1;
					if (free_cnt != '0) begin
						free_cmd_raw.pop = 1'b1;
						ins_slot         = free_top;
					end else if (used_q < eff_cap) begin
						ins_slot = IDX_W'(used_q);
						used_nxt = used_q + CNT_W'(1);
					end else begin
						// full: reuse the slot of the least recent entry
						r_evc              = 1'b1;
						cell_cmd_raw.evict = 1'b1;
						ins_slot           = last_slot;
					end
					r_slot = ins_slot;
				end
			end
			FUNC_TOUCH: begin
				if (hit) begin
					r_hit                = 1'b1;
					r_slot               = hit_slot;
					cell_cmd_raw.promote = 1'b1;
				end
			end
			FUNC_PROBE: begin
				if (hit) begin
					r_hit  = 1'b1;
					r_slot = hit_slot;
				end
			end
			FUNC_REMOVE: begin
				if (hit) begin
					r_hit               = 1'b1;
					r_slot              = hit_slot;
					cell_cmd_raw.remove = 1'b1;
					if (32'(free_cnt) < 32'(MAX_ENTRIES)) begin
						free_cmd_raw.push = 1'b1;
					end
				end
			end
			FUNC_CLEAR: begin
				cell_cmd_raw.clear = 1'b1;
				free_cmd_raw.clear = 1'b1;
				used_nxt           = '0;
			end
			default: begin
			end
		endcase
	end

	assign cell_cmd = fire ? cell_cmd_raw : '0;
	assign free_cmd = fire ? free_cmd_raw : '0;

	// occupancy = slots ever handed out minus slots waiting on the free stack
	assign occ_nxt = used_nxt - free_cnt_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (fire) begin
				used_q <= used_nxt;
			end
			if (fire) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_hit_q  <= r_hit;
			res_slot_q <= SLOT_W'(r_slot);
			res_ins_q  <= r_ins;
			res_evc_q  <= r_evc;
			res_occ_q  <= OCC_W'(occ_nxt);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = M_TDATA_W'({res_occ_q, res_slot_q});
	assign m_tuser  = {res_evc_q, res_ins_q, res_hit_q};

endmodule

FILE: rtl/lksd_checker.sv
module lksd_checker
	import lksd_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [M_TUSER_W-1:0] m_tuser
);

	logic [OCC_W-1:0] occ;

	assign occ = m_tdata[SLOT_W+OCC_W-1:SLOT_W];

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a new entry is only made on a miss
	a_ins_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0])
		else $error("insert reported together with hit");

	// eviction only happens as part of an insert
	a_evc_ins: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1])
		else $error("evict without insert");

	// no hit and no insert reports slot zero
	a_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] && !m_tuser[1] |-> m_tdata[SLOT_W-1:0] == '0)
		else $error("nonzero slot on a miss");

	// directory never holds more than its size
	a_occ_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 32'(occ) <= 32'(MAX_ENTRIES))
		else $error("occupancy above directory size");

endmodule

bind lru_key_slot_directory lksd_checker u_lksd_checker (.*);

FILE: sim/tb_lru_key_slot_directory.sv
module tb_lru_key_slot_directory;
	import lksd_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 200000;
	// two-register pipe plus margin before touching config or ending
	localparam int DRAIN_CYCLES = 6;
	// long receiver hold-off: starts once the sender is busy after this cycle
	localparam int HOLD_START   = 400;
	localparam int HOLD_LEN     = 150;

	// codes past clear do nothing but report occupancy
	localparam logic [FUNC_W-1:0] FUNC_NOP_LO = FUNC_CLEAR + 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_NOP_HI = '1;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [COORD_W-1:0] key_x;
		logic [COORD_W-1:0] key_z;
	} dir_req_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              inserted;
		logic              evicted;
		logic [OCC_W-1:0]  occ;
	} dir_resp_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CAP_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // key_x[31:0], key_z[63:32]
	logic [S_TUSER_W-1:0] s_tuser;   // func[2:0]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // slot[7:0], occupancy[16:8], zero pad
	logic [M_TUSER_W-1:0] m_tuser;   // hit[0], inserted[1], evicted[2]

	lru_key_slot_directory uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// shadow directory: cells 0..n-1 held in recency order, cell 0 newest,
	// n = used_cnt - free_cnt
	logic [KEY_W-1:0]  dir_key  [MAX_ENTRIES];
	logic [SLOT_W-1:0] dir_slot [MAX_ENTRIES];
	logic [SLOT_W-1:0] freed    [MAX_ENTRIES];
	int                free_cnt = 0;
	int                used_cnt = 0;
	logic [CAP_W-1:0]  cap_reg  = CAP_RESET;

	dir_req_t          pending_ops[$];
	dir_resp_t         expected_resp[$];
	logic [KEY_W-1:0]  key_pool[$];
	int                queued_total = 0;
	int                results_seen = 0;
	int                errors = 0;

	// sender burst state
	int                burst_left = 0;
	int                gap_left = 0;
	dir_req_t          drv_next;

	// receiver state
	int                rx_cycle = 0;
	int                rx_mode = 0;
	int                hold_left = 0;
	bit                hold_done = 0;

	int                cycle_cnt = 0;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Directory behavior: one call per accepted item, returns the result
	// it must produce and updates the shadow state.
	function automatic dir_resp_t directory_update(input logic [FUNC_W-1:0] func,
			input logic [KEY_W-1:0] key);
		dir_resp_t r;
		int n;
		int h;
		int eff;
		r = '0;
		n = used_cnt - free_cnt;
		h = -1;
		if (func == FUNC_CLEAR) begin
			free_cnt = 0;
			used_cnt = 0;
		end else if (func <= FUNC_REMOVE) begin
			for (int i = 0; i < n; i++)
				if (h < 0 && dir_key[i] == key)
					h = i;
			if (h >= 0) begin
				r.hit  = 1'b1;
				r.slot = dir_slot[h];
				if (func == FUNC_LOOKUP_INSERT || func == FUNC_TOUCH) begin
					// move to newest
					for (int i = h; i > 0; i--) begin
						dir_key[i]  = dir_key[i-1];
						dir_slot[i] = dir_slot[i-1];
					end
					dir_key[0]  = key;
					dir_slot[0] = r.slot;
				end else if (func == FUNC_REMOVE) begin
					if (free_cnt < MAX_ENTRIES) begin
						freed[free_cnt] = r.slot;
						free_cnt++;
					end
					for (int i = h; i < n - 1; i++) begin
						dir_key[i]  = dir_key[i+1];
						dir_slot[i] = dir_slot[i+1];
					end
				end
			end else if (func == FUNC_LOOKUP_INSERT) begin
				// 0 acts as 1, above the array size acts as the array size
				eff = int'(cap_reg);
				if (eff < 1)
					eff = 1;
				if (eff > MAX_ENTRIES)
					eff = MAX_ENTRIES;
				if (free_cnt > 0) begin
					free_cnt--;
					r.slot = freed[free_cnt];
				end else if (used_cnt < eff) begin
					r.slot = SLOT_W'(used_cnt);
					used_cnt++;
				end else begin
					// full (or capacity lowered below use): reuse the LRU slot
					r.evicted = 1'b1;
					r.slot    = dir_slot[n-1];
					n--;
				end
				for (int i = n; i > 0; i--) begin
					dir_key[i]  = dir_key[i-1];
					dir_slot[i] = dir_slot[i-1];
				end
				dir_key[0]  = key;
				dir_slot[0] = r.slot;
				r.inserted  = 1'b1;
			end
		end
		r.occ = OCC_W'(used_cnt - free_cnt);
		return r;
	endfunction

	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// mostly reuse keys from a bounded pool so hits, touches and removes land
	function automatic logic [KEY_W-1:0] pick_key(input int fresh_pct, input int pool_limit);
		logic [KEY_W-1:0] k;
		if (key_pool.size() == 0 || $urandom_range(0, 99) < fresh_pct) begin
			k = {rand_coord(), rand_coord()};
			key_pool.insert(key_pool.size(), k);
			if (key_pool.size() > pool_limit)
				key_pool.delete($urandom_range(0, key_pool.size() - 1));
		end else begin
			k = key_pool[$urandom_range(0, key_pool.size() - 1)];
		end
		return k;
	endfunction

	task automatic push_item(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key);
		dir_req_t it;
		it.func  = func;
		it.key_x = key[KEY_W-1:COORD_W];
		it.key_z = key[COORD_W-1:0];
		pending_ops.insert(pending_ops.size(), it);
		queued_total++;
	endtask

	task automatic random_phase(input int count, input int pool_limit, input int fresh_pct,
			input int insert_pct, input int clear_pct);
		logic [FUNC_W-1:0] f;
		int roll;
		while (key_pool.size() > pool_limit)
			key_pool.delete(0);
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < clear_pct)
				f = FUNC_CLEAR;
			else if (roll < clear_pct + 2)
				f = FUNC_W'($urandom_range(FUNC_NOP_LO, FUNC_NOP_HI));
			else if (roll < clear_pct + 2 + insert_pct)
				f = FUNC_LOOKUP_INSERT;
			else begin
				case ($urandom_range(0, 2))
					0: f = FUNC_TOUCH;
					1: f = FUNC_PROBE;
					default: f = FUNC_REMOVE;
				endcase
			end
			push_item(f, pick_key(fresh_pct, pool_limit));
		end
	endtask

	// every item yields one result, so all results in means the pipe is empty
	task automatic wait_idle();
		while (results_seen < queued_total)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cap_reg = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Stimulus: directed corner cases at reset capacity, then random phases
	// across several capacity settings.
	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// fresh inserts with extreme keys, then a repeat hit
		push_item(FUNC_LOOKUP_INSERT, {32'h7FFF_FFFF, 32'h8000_0000});
		push_item(FUNC_LOOKUP_INSERT, {32'h8000_0000, 32'h7FFF_FFFF});
		push_item(FUNC_LOOKUP_INSERT, {32'h0000_0000, 32'h0000_0000});
		push_item(FUNC_LOOKUP_INSERT, {32'hFFFF_FFFF, 32'hFFFF_FFFF});
		push_item(FUNC_LOOKUP_INSERT, {32'h7FFF_FFFF, 32'h8000_0000});
		// touch and probe, hit and miss
		push_item(FUNC_TOUCH,         {32'h8000_0000, 32'h7FFF_FFFF});
		push_item(FUNC_TOUCH,         {32'h0000_0001, 32'h0000_0002});
		push_item(FUNC_PROBE,         {32'h0000_0000, 32'h0000_0000});
		push_item(FUNC_PROBE,         {32'h0000_0001, 32'h0000_0002});
		// remove hit, remove miss, then an insert takes the freed slot
		push_item(FUNC_REMOVE,        {32'h0000_0000, 32'h0000_0000});
		push_item(FUNC_REMOVE,        {32'h0000_0000, 32'h0000_0000});
		push_item(FUNC_LOOKUP_INSERT, {32'h0000_0001, 32'h0000_0002});
		// unused codes leave everything alone
		for (int f = FUNC_NOP_LO; f <= FUNC_NOP_HI; f++)
			push_item(FUNC_W'(f), {32'hFFFF_FFFF, 32'hFFFF_FFFF});
		// clear, then the directory starts over from slot 0
		push_item(FUNC_CLEAR,         {32'hFFFF_FFFF, 32'hFFFF_FFFF});
		push_item(FUNC_PROBE,         {32'h7FFF_FFFF, 32'h8000_0000});
		push_item(FUNC_LOOKUP_INSERT, {32'h0000_0000, 32'h0000_0000});
		push_item(FUNC_REMOVE,        {32'h0000_0000, 32'h0000_0000});
		push_item(FUNC_REMOVE,        {32'h7FFF_FFFF, 32'h8000_0000});

		write_capacity(CAP_W'(1));
		random_phase(100, 6, 20, 45, 3);
		write_capacity('0);
		random_phase(60, 4, 20, 45, 3);
		write_capacity(CAP_W'(4));
		random_phase(200, 10, 15, 40, 2);
		// lowered below what is already in use, no clear in between
		write_capacity(CAP_W'(3));
		random_phase(100, 10, 15, 40, 0);
		// top of the register range acts as full size; fill past it to evict
		write_capacity('1);
		push_item(FUNC_CLEAR, {rand_coord(), rand_coord()});
		random_phase(600, 400, 50, 75, 0);
		write_capacity(CAP_W'(256));
		random_phase(200, 20, 15, 40, 3);
		write_capacity(CAP_W'(2));
		random_phase(100, 8, 20, 45, 3);

		wait_idle();
		if (expected_resp.size() != 0) begin
			$error("%0d expected results never arrived", expected_resp.size());
			errors++;
		end
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Sender: bursts of random length, random gaps between them. The item
	// is predicted at the edge it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_resp.insert(expected_resp.size(), directory_update(s_tuser,
						{s_tdata[COORD_W-1:0], s_tdata[KEY_W-1:COORD_W]}));
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					drv_next = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= drv_next.func;
					s_tdata  <= {drv_next.key_z, drv_next.key_x};
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						// a third of the bursts run straight into the next
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: a randomly chosen stall pattern; one long hold-off
	// while the sender is active backs the block up into its input.
	always @(posedge clk) begin
		rx_cycle++;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!hold_done && rx_cycle >= HOLD_START && s_tvalid) begin
			hold_done = 1'b1;
			hold_left = HOLD_LEN;
			m_tready <= 1'b0;
		end else begin
			if (rx_cycle % 50 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= (rx_cycle % 4 != 3);
				default: m_tready <= ($urandom_range(0, 1) != 0);
			endcase
		end
	end

	// Result checker: each taken result against the oldest expectation.
	always @(posedge clk) begin
		dir_resp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_resp.size() == 0) begin
				$error("result item with nothing expected");
				errors++;
			end else begin
				want = expected_resp.pop_front();
				check_field("hit", want.hit, m_tuser[0]);
				check_field("slot", want.slot, m_tdata[SLOT_W-1:0]);
				check_field("inserted", want.inserted, m_tuser[1]);
				check_field("evicted", want.evicted, m_tuser[2]);
				check_field("occupancy", want.occ, m_tdata[SLOT_W+OCC_W-1:SLOT_W]);
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule
